// ===== hdl/skt_pkg.sv =====
// Package for the sorted key table: sizes, field structs, codes and state type.
// No dependencies; used by sorted_key_table.
package skt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 16;

  localparam int KEY_W   = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W   = (CNT_W > 7) ? CNT_W : 7;
  localparam int ENTRY_W = KEY_W + 16;

  typedef enum logic {
    OP_SEARCH = 1'b0,
    OP_INSERT = 1'b1
  } skt_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2,
    ST_FULL   = 2'd3
  } skt_status_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] key;
    logic [6:0]  position;
    logic [15:0] payload;
  } skt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  index;
    logic [15:0] found_payload;
  } skt_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_ICHK0,
    S_ICMP0,
    S_ICHK1,
    S_ICMP1,
    S_IFULL,
    S_SHIFT,
    S_SWR
  } skt_state_t;

endpackage

// ===== hdl/sorted_key_table.sv =====
// Sorted key table top level: sequencer for binary search and shifting insert.
// Depends on skt_pkg and skt_ram (one RAM holding key and payload per entry).
//
//   channel  ports                          handshake
//   input    start, busy, in_item           beat taken when start && !busy
//   result   out_valid, out_item            one-cycle strobe, always taken
//
// Each memory read has an issue state and a compare state; the strobe is
// registered. A search makes r probes, r <= log2(TABLE_DEPTH) + 1. An insert
// runs its checks, shifts each entry at or above the position up one slot
// (read, then write), then writes the new entry; a rejected beat ends at its
// failing check. busy drops in the strobe cycle; results never stall.
// Synchronous reset clears the entry count and control, not the RAM.
module sorted_key_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  skt_pkg::skt_in_t  in_item,
  output logic              out_valid,
  output skt_pkg::skt_out_t out_item
);
  import skt_pkg::*;

  skt_state_t       state_r, state_nxt;
  logic             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [6:0]       pos_r, pos_nxt;
  logic [15:0]      pay_r, pay_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  skt_out_t         out_r, out_nxt;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [KEY_W-1:0]   rd_key;
  logic [15:0]        rd_pay;
  logic [CNT_W:0]     mid_sum;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   idx_ext;

  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key  = rd_data[ENTRY_W-1:16];
  assign rd_pay  = rd_data[15:0];
  assign mid_sum = ({1'b0, lo_r} + {1'b0, hi_r}) >> 1;
  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(cnt_r);
  assign idx_ext = CMP_W'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r  <= op_nxt;
    key_r <= key_nxt;
    pos_r <= pos_nxt;
    pay_r <= pay_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    pay_nxt       = pay_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_item.opcode;
          key_nxt = in_item.key[KEY_W-1:0];
          pos_nxt = in_item.position;
          pay_nxt = in_item.payload;
          lo_nxt  = '0;
          hi_nxt  = cnt_r;
          state_nxt = (in_item.opcode == OP_INSERT) ? S_ICHK0 : S_SRCH;
        end
      end

      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CNT_W-1:0];
          rd_en     = 1'b1;
          rd_addr   = mid_sum[ADDR_W-1:0];
          state_nxt = S_SCMP;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_MISS, index: 7'(lo_r), found_payload: 16'd0};
          state_nxt     = S_IDLE;
        end
      end

      S_SCMP: begin
        if (key_r < rd_key) begin
          hi_nxt    = mid_r;
          state_nxt = S_SRCH;
        end else if (key_r > rd_key) begin
          lo_nxt    = mid_r + 1'b1;
          state_nxt = S_SRCH;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_OK, index: 7'(mid_r), found_payload: rd_pay};
          state_nxt     = S_IDLE;
        end
      end

      S_ICHK0: begin
        if (pos_ext > cnt_ext) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_REJECT, index: 7'd0, found_payload: 16'd0};
          state_nxt     = S_IDLE;
        end else if (pos_r != 7'd0) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(pos_r - 7'd1);
          state_nxt = S_ICMP0;
        end else begin
          state_nxt = S_ICHK1;
        end
      end

      S_ICMP0: begin
        if (key_r <= rd_key) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_REJECT, index: 7'd0, found_payload: 16'd0};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_ICHK1;
        end
      end

      S_ICHK1: begin
        if (pos_ext < cnt_ext) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(pos_r);
          state_nxt = S_ICMP1;
        end else begin
          state_nxt = S_IFULL;
        end
      end

      S_ICMP1: begin
        if (key_r >= rd_key) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_REJECT, index: 7'd0, found_payload: 16'd0};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_IFULL;
        end
      end

      S_IFULL: begin
        if (cnt_r >= CNT_W'(TABLE_DEPTH)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_FULL, index: 7'd0, found_payload: 16'd0};
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = cnt_r;
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (idx_ext > pos_ext) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(idx_r - 1'b1);
          state_nxt = S_SWR;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = ADDR_W'(pos_r);
          wr_data       = {key_r, pay_r};
          cnt_nxt       = cnt_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_OK, index: pos_r, found_payload: 16'd0};
          state_nxt     = S_IDLE;
        end
      end

      S_SWR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[ADDR_W-1:0];
        wr_data   = rd_data;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_SHIFT;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r == OP_INSERT && out_item.status == ST_OK)
      |-> cnt_r == $past(cnt_r) + 1'b1)
    else $error("successful insert did not bump the entry count");
`endif

endmodule

// ===== hdl/skt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
